FILE: hdl/ues_pkg.sv
`timescale 1ns / 1ps

package ues_pkg;

  localparam int UNIT_W = 16;
  localparam int CP_W   = 21;

  localparam logic [UNIT_W-1:0] HIGH_SURR_LO = 16'hD800;
  localparam logic [UNIT_W-1:0] HIGH_SURR_HI = 16'hDBFF;
  localparam logic [UNIT_W-1:0] LOW_SURR_LO  = 16'hDC00;
  localparam logic [UNIT_W-1:0] LOW_SURR_HI  = 16'hDFFF;
  localparam logic [CP_W-1:0]   SUPP_BASE    = 21'h10000;

  localparam logic [CP_W-1:0] CP_ZWJ      = 21'h0200D;
  localparam logic [CP_W-1:0] CP_VS16     = 21'h0FE0F;
  localparam logic [CP_W-1:0] CP_KEYCAP   = 21'h020E3;
  localparam logic [CP_W-1:0] CP_TONE_LO  = 21'h1F3FB;
  localparam logic [CP_W-1:0] CP_TONE_HI  = 21'h1F3FF;
  localparam logic [CP_W-1:0] CP_RI_LO    = 21'h1F1E6;
  localparam logic [CP_W-1:0] CP_RI_HI    = 21'h1F1FF;

  localparam int NUM_RANGES = 33;

  localparam logic [CP_W-1:0] EMOJI_LO [NUM_RANGES] = '{
    21'h1F600, 21'h1F300, 21'h1F680, 21'h1F900, 21'h1FA00, 21'h02600,
    21'h02300, 21'h02B00, 21'h1F1E6, 21'h1F3FB, 21'h0200D, 21'h020E3,
    21'h02764, 21'h02B50, 21'h000A9, 21'h000AE, 21'h02122, 21'h0231A,
    21'h02328, 21'h024C2, 21'h025AA, 21'h02934, 21'h02B05, 21'h02B1B,
    21'h02B55, 21'h03030, 21'h0303D, 21'h03297, 21'h03299, 21'h1F000,
    21'h1F0A0, 21'h1F100, 21'h1F200
  };

  localparam logic [CP_W-1:0] EMOJI_HI [NUM_RANGES] = '{
    21'h1F64F, 21'h1F5FF, 21'h1F6FF, 21'h1F9FF, 21'h1FAFF, 21'h027BF,
    21'h023FF, 21'h02BFF, 21'h1F1FF, 21'h1F3FF, 21'h0200D, 21'h020E3,
    21'h02764, 21'h02B50, 21'h000A9, 21'h000AE, 21'h02139, 21'h0231B,
    21'h023CF, 21'h024C2, 21'h025FE, 21'h02935, 21'h02B07, 21'h02B1C,
    21'h02B55, 21'h03030, 21'h0303D, 21'h03297, 21'h03299, 21'h1F02F,
    21'h1F0FF, 21'h1F1FF, 21'h1F251
  };

  typedef enum logic [2:0] {
    SCAN_IDLE = 3'b001,
    SCAN_RUN  = 3'b010,
    SCAN_ZWJ  = 3'b100
  } scan_mode_t;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'b001,
    KIND_PLAIN = 3'b010,
    KIND_EMOJI = 3'b100
  } kind_t;

  typedef struct packed {
    logic       emo;
    logic       start;
    scan_mode_t mode;
    logic       flag;
    kind_t      kind;
  } cls_t;

  function automatic logic emoji_hit(input logic [CP_W-1:0] cp);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NUM_RANGES; i++) begin
      if (cp >= EMOJI_LO[i] && cp <= EMOJI_HI[i]) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic cls_t classify(input logic [CP_W-1:0] cp, input scan_mode_t mode,
                                    input logic flag, input kind_t kind);
    cls_t c;
    logic table_hit;
    logic regional;
    logic fall;
    table_hit = emoji_hit(cp);
    regional  = (cp >= CP_RI_LO) && (cp <= CP_RI_HI);
    c.emo   = 1'b0;
    c.start = 1'b0;
    c.mode  = SCAN_IDLE;
    c.flag  = flag;
    c.kind  = kind;
    fall    = 1'b1;
    case (mode)
      SCAN_RUN: begin
        fall = 1'b0;
        c.emo = 1'b1;
        if ((cp >= CP_TONE_LO && cp <= CP_TONE_HI) || cp == CP_VS16) begin
          c.mode = SCAN_RUN;
        end else if (flag && regional) begin
          c.mode = SCAN_IDLE;
        end else if (cp == CP_KEYCAP) begin
          c.mode = SCAN_IDLE;
        end else if (cp == CP_ZWJ) begin
          c.mode = SCAN_ZWJ;
        end else begin
          c.emo = 1'b0;
          fall  = 1'b1;
        end
      end
      SCAN_ZWJ: begin
        // emoji after a joiner continues the sequence
        if (table_hit) begin
          fall   = 1'b0;
          c.emo  = 1'b1;
          c.flag = regional;
          c.mode = SCAN_RUN;
        end
      end
      default: fall = 1'b1;
    endcase
    if (fall) begin
      if (table_hit) begin
        c.emo   = 1'b1;
        c.start = 1'b1;
        c.flag  = regional;
        c.mode  = SCAN_RUN;
        c.kind  = KIND_EMOJI;
      end else begin
        c.emo   = 1'b0;
        c.start = (kind != KIND_PLAIN);
        c.mode  = SCAN_IDLE;
        c.kind  = KIND_PLAIN;
      end
    end
    return c;
  endfunction

endpackage

FILE: hdl/ues_in_if.sv
`timescale 1ns / 1ps

interface ues_in_if;
  logic                       valid;
  logic                       ready;
  logic [ues_pkg::UNIT_W-1:0] code_unit;
  logic                       end_of_text;

  modport source (output valid, output code_unit, output end_of_text, input ready);
  modport sink   (input valid, input code_unit, input end_of_text, output ready);
endinterface

FILE: hdl/ues_out_if.sv
`timescale 1ns / 1ps

interface ues_out_if;
  logic                       valid;
  logic                       ready;
  logic [ues_pkg::UNIT_W-1:0] unit_out;
  logic [ues_pkg::CP_W-1:0]   codepoint;
  logic                       is_emoji;
  logic                       run_start;
  logic                       text_end;

  modport source (output valid, output unit_out, output codepoint, output is_emoji,
                  output run_start, output text_end, input ready);
  modport sink   (input valid, input unit_out, input codepoint, input is_emoji,
                  input run_start, input text_end, output ready);
endinterface

FILE: hdl/utf16_emoji_run_segmenter_unit.sv
`timescale 1ns / 1ps
// a taken unit goes into the input register and its results into the output register;
// the low half of a pair follows the high half
// throughput: one unit per cycle while the output is not stalled; a unit that yields
// two results (a completed pair, or a unit after a lone high surrogate) holds the input
// register until both are out; a held high surrogate yields nothing and frees the register
// reset (rst_n low, synchronous): registers empty, no held unit, no run open, enable set
module utf16_emoji_run_segmenter_unit (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  ues_in_if.sink    in_chan,
  ues_out_if.source out_chan
);
  import ues_pkg::*;

  logic              enable_r;
  logic              iv_r, iv_nxt;
  logic [UNIT_W-1:0] iunit_r;
  logic              ieot_r;

  logic [UNIT_W-1:0] held_high_r, held_high_nxt;
  logic              held_valid_r, held_valid_nxt;
  scan_mode_t        scan_mode_r, scan_mode_nxt;
  logic              flag_r, flag_nxt;
  kind_t             kind_r, kind_nxt;
  logic              pair_r, pair_nxt;
  logic [CP_W-1:0]   pcp_r;
  logic              pemo_r;

  logic              out_valid_r;
  logic [UNIT_W-1:0] out_unit_r;
  logic [CP_W-1:0]   out_cp_r;
  logic              out_emo_r, out_start_r, out_end_r;

  logic              unit_high, unit_low;
  logic [CP_W-1:0]   pair_cp;
  logic [CP_W-1:0]   cls_cp;
  cls_t              cls;
  logic              use_cls;
  logic              step_emit, step_done;
  logic [UNIT_W-1:0] res_unit;
  logic [CP_W-1:0]   res_cp;
  logic              res_emo, res_start, res_end;
  logic              out_free, fire, accept, in_ready;

  assign unit_high = (iunit_r >= HIGH_SURR_LO) && (iunit_r <= HIGH_SURR_HI);
  assign unit_low  = (iunit_r >= LOW_SURR_LO) && (iunit_r <= LOW_SURR_HI);
  assign pair_cp   = SUPP_BASE + {1'b0, held_high_r[9:0], iunit_r[9:0]};

  always_comb begin
    step_emit      = 1'b0;
    step_done      = 1'b0;
    use_cls        = 1'b0;
    cls_cp         = {{(CP_W-UNIT_W){1'b0}}, iunit_r};
    res_unit       = iunit_r;
    res_cp         = {{(CP_W-UNIT_W){1'b0}}, iunit_r};
    res_end        = 1'b0;
    held_high_nxt  = held_high_r;
    held_valid_nxt = held_valid_r;
    pair_nxt       = 1'b0;
    if (pair_r) begin
      // low half of a pair: reuses the classification of the high half
      step_emit = 1'b1;
      step_done = 1'b1;
      res_cp    = pcp_r;
      res_end   = ieot_r;
    end else if (held_valid_r && unit_low) begin
      step_emit      = 1'b1;
      use_cls        = 1'b1;
      cls_cp         = pair_cp;
      res_unit       = held_high_r;
      res_cp         = pair_cp;
      held_valid_nxt = 1'b0;
      pair_nxt       = 1'b1;
    end else if (held_valid_r) begin
      // lone high surrogate goes out first, then the new unit is handled
      step_emit      = 1'b1;
      use_cls        = 1'b1;
      cls_cp         = {{(CP_W-UNIT_W){1'b0}}, held_high_r};
      res_unit       = held_high_r;
      res_cp         = {{(CP_W-UNIT_W){1'b0}}, held_high_r};
      held_valid_nxt = 1'b0;
      if (unit_high && !ieot_r) begin
        held_high_nxt  = iunit_r;
        held_valid_nxt = 1'b1;
        step_done      = 1'b1;
      end
    end else if (unit_high && !ieot_r) begin
      held_high_nxt  = iunit_r;
      held_valid_nxt = 1'b1;
      step_done      = 1'b1;
    end else begin
      step_emit = 1'b1;
      step_done = 1'b1;
      use_cls   = 1'b1;
      res_end   = ieot_r;
    end

    cls = classify(cls_cp, scan_mode_r, flag_r, kind_r);

    res_emo       = pemo_r;
    res_start     = 1'b0;
    scan_mode_nxt = scan_mode_r;
    flag_nxt      = flag_r;
    kind_nxt      = kind_r;
    if (use_cls) begin
      res_emo       = cls.emo;
      res_start     = cls.start;
      scan_mode_nxt = cls.mode;
      flag_nxt      = cls.flag;
      kind_nxt      = cls.kind;
    end
    if (step_done && ieot_r) begin
      held_high_nxt  = '0;
      held_valid_nxt = 1'b0;
      scan_mode_nxt  = SCAN_IDLE;
      flag_nxt       = 1'b0;
      kind_nxt       = KIND_NONE;
    end
  end

  assign out_free = !out_valid_r || out_chan.ready;
  assign fire     = iv_r && (!step_emit || out_free);
  assign in_ready = !iv_r || (fire && step_done);
  assign accept   = in_chan.valid && in_ready;

  always_comb begin
    iv_nxt = iv_r;
    if (fire && step_done) iv_nxt = 1'b0;
    // disabled: the request is taken and dropped
    if (accept) iv_nxt = enable_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b1;
      iv_r         <= 1'b0;
      held_high_r  <= '0;
      held_valid_r <= 1'b0;
      scan_mode_r  <= SCAN_IDLE;
      flag_r       <= 1'b0;
      kind_r       <= KIND_NONE;
      pair_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) enable_r <= cfg_wr_data;
      iv_r <= iv_nxt;
      if (fire) begin
        held_high_r  <= held_high_nxt;
        held_valid_r <= held_valid_nxt;
        scan_mode_r  <= scan_mode_nxt;
        flag_r       <= flag_nxt;
        kind_r       <= kind_nxt;
        pair_r       <= pair_nxt;
      end
      if (fire && step_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      iunit_r <= in_chan.code_unit;
      ieot_r  <= in_chan.end_of_text;
    end
    if (fire) begin
      pcp_r  <= pair_cp;
      pemo_r <= res_emo;
    end
    if (fire && step_emit) begin
      out_unit_r  <= res_unit;
      out_cp_r    <= res_cp;
      out_emo_r   <= res_emo;
      out_start_r <= res_start;
      out_end_r   <= res_end;
    end
  end

  assign in_chan.ready      = in_ready;
  assign out_chan.valid     = out_valid_r;
  assign out_chan.unit_out  = out_unit_r;
  assign out_chan.codepoint = out_cp_r;
  assign out_chan.is_emoji  = out_emo_r;
  assign out_chan.run_start = out_start_r;
  assign out_chan.text_end  = out_end_r;

  a_pair_no_held: assert property (@(posedge clk) disable iff (!rst_n)
    pair_r |-> !held_valid_r)
    else $error("pair second half pending while a high surrogate is held");

  a_pair_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    pair_r |-> iv_r)
    else $error("pair second half pending with no unit in the input register");

  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && step_done && ieot_r) |=>
      (!held_valid_r && scan_mode_r == SCAN_IDLE && kind_r == KIND_NONE && !flag_r))
    else $error("stream state not cleared after end of text");

  a_low_half_no_start: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && pair_r) |=> (out_valid_r && !out_start_r))
    else $error("low half of a pair marked as run start");

endmodule
